@@ sv/gcs_pkg.sv @@
// Shared types and constants for the grey-level contrast stretch core.
// Used by every module of the block; no dependencies of its own.
package gcs_pkg;

    localparam int PIX_W       = 8;
    localparam int NUM_W       = 2 * PIX_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W      = $clog2(PIX_W);

    localparam logic [PIX_W-1:0]  FULL_SCALE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0]  MIN_RESET  = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0]  MAX_RESET  = {PIX_W{1'b0}};
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(PIX_W - 1);

    // One queued stretch job: either a ready value (is_div low, value in
    // num[PIX_W-1:0]) or a division num / den with the quotient below 2**PIX_W.
    typedef struct packed {
        logic             is_div;
        logic [NUM_W-1:0] num;
        logic [PIX_W-1:0] den;
    } gcs_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } gcs_state_t;

endpackage

@@ sv/gcs_front.sv @@
// Front end: takes input transfers, tracks the running min/max and
// classifies stretch pixels into queue jobs. Depends on gcs_pkg.
module gcs_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic                      s_first,
    input  logic [gcs_pkg::PIX_W-1:0] s_pixel,
    input  logic                      q_full,
    output logic                      push,
    output gcs_pkg::gcs_entry_t       entry
);
    import gcs_pkg::*;

    logic [PIX_W-1:0] run_min_reg, run_min_next;
    logic [PIX_W-1:0] run_max_reg, run_max_next;
    logic             accept;
    logic [PIX_W-1:0] offset;
    logic [PIX_W-1:0] range;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_action;

    always_comb begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        if (accept && !s_action) begin
            if (s_first) begin
                run_min_next = s_pixel;
                run_max_next = s_pixel;
            end else begin
                if (s_pixel < run_min_reg) begin
                    run_min_next = s_pixel;
                end
                if (s_pixel > run_max_reg) begin
                    run_max_next = s_pixel;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg <= MIN_RESET;
            run_max_reg <= MAX_RESET;
        end else begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

    assign offset = s_pixel - run_min_reg;
    assign range  = run_max_reg - run_min_reg;

    // Flat or empty range and out-of-range pixels bypass the divider.
    always_comb begin
        entry.is_div = 1'b0;
        entry.num    = '0;
        entry.den    = range;
        if (run_max_reg <= run_min_reg || s_pixel < run_min_reg) begin
            entry.num = '0;
        end else if (s_pixel > run_max_reg) begin
            entry.num = {{(NUM_W-PIX_W){1'b0}}, FULL_SCALE};
        end else begin
            entry.is_div = 1'b1;
            // offset * 255 as (offset << 8) - offset
            entry.num    = {offset, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, offset};
        end
    end

`ifndef NO_ASSERTIONS
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_action) |=> (run_min_reg <= run_max_reg))
        else $error("min above max after a measure transfer");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && entry.is_div) |-> (entry.den != '0))
        else $error("division job with zero divisor");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("push into full queue");
`endif

endmodule

@@ sv/gcs_queue.sv @@
// Short register queue of stretch jobs between front end and divider.
// Depends on gcs_pkg for the entry type and depth.
module gcs_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gcs_pkg::gcs_entry_t push_entry,
    input  logic                pop,
    output gcs_pkg::gcs_entry_t head,
    output logic                full,
    output logic                empty
);
    import gcs_pkg::*;

    gcs_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");
`endif

endmodule

@@ sv/gcs_divide.sv @@
// Back end: radix-2 restoring divider, one quotient bit a cycle, plus the
// output register of the result channel. Depends on gcs_pkg.
module gcs_divide (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  gcs_pkg::gcs_entry_t       q_head,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [gcs_pkg::PIX_W-1:0] m_stretched
);
    import gcs_pkg::*;

    gcs_state_t        state_reg, state_next;
    logic [PIX_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  dvd_reg, dvd_next;
    logic [PIX_W-1:0]  den_reg, den_next;
    logic [PIX_W-1:0]  res_reg, res_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PIX_W:0]    trial;
    logic              qbit;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = q_head.is_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        pop     = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: pop     = !q_empty;
            ST_DIV:  pop     = 1'b0;
            ST_OUT:  m_valid = 1'b1;
            default: begin
                pop     = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign trial = {rem_reg, dvd_reg[PIX_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    // Datapath
    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        res_next  = res_reg;
        step_next = step_reg;
        if (pop) begin
            rem_next  = q_head.num[NUM_W-1:PIX_W];
            dvd_next  = q_head.num[PIX_W-1:0];
            den_next  = q_head.den;
            step_next = '0;
            res_next  = q_head.num[PIX_W-1:0];
        end else if (state_reg == ST_DIV) begin
            // shift in one dividend bit, subtract when it fits
            rem_next  = qbit ? PIX_W'(trial - {1'b0, den_reg}) : trial[PIX_W-1:0];
            dvd_next  = {dvd_reg[PIX_W-2:0], qbit};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                res_next = {dvd_reg[PIX_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        res_reg  <= res_next;
        step_reg <= step_next;
    end

    assign m_stretched = res_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");
    a_div_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == STEP_LAST) |=> (state_reg == ST_OUT))
        else $error("division did not finish after its last step");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_ready) |=> (state_reg == ST_OUT && $stable(res_reg)))
        else $error("stalled result lost");
`endif

endmodule

@@ sv/grey_contrast_stretch_core.sv @@
// Grey-level min/max contrast stretch for 8-bit pixels.
// Channels: s_* input pixels (action, first, pixel) and m_* stretched
// results, both valid/ready; a transfer happens when valid and ready are high.
// Measure pixels (action low) update the running min/max and give no result;
// first high restarts the search from that pixel. Stretch pixels (action
// high) give one result each, (pixel - min) * 255 / (max - min) truncated,
// 0 for a flat or empty range or a pixel below it, 255 for one above it.
// A stretch job is written to the queue at its input transfer and popped when
// the divider is idle; a job that needs division then passes through 8 divider
// steps before its result is registered for output.
// The radix-2 divider sets the rate and takes no new job until the last result
// has transferred. Measure pixels transfer every cycle while the 2-entry job
// queue has room; stretch jobs keep a copy of the range, so the next frame can
// be measured while they drain.
// Reset (aresetn low, synchronous) empties the queue and divider and sets
// min to 255 and max to 0. When m_ready is low the result holds in its
// output register; the queue then fills and s_ready drops.
module grey_contrast_stretch_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic                      s_first,
    input  logic [gcs_pkg::PIX_W-1:0] s_pixel,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [gcs_pkg::PIX_W-1:0] m_stretched
);
    import gcs_pkg::*;

    gcs_entry_t push_entry;
    gcs_entry_t head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    gcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_first  (s_first),
        .s_pixel  (s_pixel),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    gcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    gcs_divide u_divide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_stretched (m_stretched)
    );

endmodule

@@ bench/tb.sv @@
// Testbench for grey_contrast_stretch_core: a directed table of pixels, then random frames.
// Every stretched pixel is checked against a typed table value or a min/max stretch predictor kept in the bench.
// Depends on gcs_pkg and grey_contrast_stretch_core.
module tb;

    localparam int PW          = gcs_pkg::PIX_W;
    localparam int TOTAL_ITEMS = 1350;
    localparam int CALM_ITEMS  = 150;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_STRETCH = 1'b1;

    typedef struct packed {
        logic          action;
        logic          first;
        logic [PW-1:0] pixel;
        logic          known;
        logic [PW-1:0] value;
    } pix_row_t;

    localparam int N_ROWS = 25;

    // Typed values are those that follow at a glance from the range; the rest use the predictor.
    localparam pix_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ACT_STRETCH, 1'b0, 8'd0,   1'b1, 8'd0},    // no range yet after reset
        '{ACT_STRETCH, 1'b1, 8'd255, 1'b1, 8'd0},
        '{ACT_MEASURE, 1'b1, 8'd100, 1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd100, 1'b1, 8'd0},    // flat range
        '{ACT_STRETCH, 1'b0, 8'd255, 1'b1, 8'd0},
        '{ACT_MEASURE, 1'b0, 8'd0,   1'b0, 8'd0},
        '{ACT_MEASURE, 1'b0, 8'd255, 1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd0,   1'b1, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd255, 1'b1, 8'd255},
        '{ACT_STRETCH, 1'b1, 8'd128, 1'b1, 8'd128},
        '{ACT_STRETCH, 1'b0, 8'd1,   1'b1, 8'd1},
        '{ACT_MEASURE, 1'b1, 8'd50,  1'b0, 8'd0},    // restart the search
        '{ACT_MEASURE, 1'b0, 8'd200, 1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd10,  1'b1, 8'd0},    // below range
        '{ACT_STRETCH, 1'b0, 8'd250, 1'b1, 8'd255},  // above range
        '{ACT_STRETCH, 1'b0, 8'd50,  1'b1, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd200, 1'b1, 8'd255},
        '{ACT_STRETCH, 1'b1, 8'd51,  1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd199, 1'b0, 8'd0},
        '{ACT_MEASURE, 1'b1, 8'd255, 1'b0, 8'd0},
        '{ACT_MEASURE, 1'b1, 8'd0,   1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd255, 1'b1, 8'd0},    // flat at zero
        '{ACT_MEASURE, 1'b0, 8'd1,   1'b0, 8'd0},
        '{ACT_STRETCH, 1'b0, 8'd1,   1'b1, 8'd255},
        '{ACT_STRETCH, 1'b0, 8'd170, 1'b1, 8'd255}
    };

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic          s_action;
    logic          s_first;
    logic [PW-1:0] s_pixel;
    logic          m_valid;
    logic          m_ready;
    logic [PW-1:0] m_stretched;

    logic [PW-1:0] range_lo;
    logic [PW-1:0] range_hi;
    logic [PW-1:0] stretched_q [$];
    int            err_count;
    int            n_items;
    int            cycle_count;
    int            rx_left;
    bit            calm;

    grey_contrast_stretch_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_first     (s_first),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_stretched (m_stretched)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [PW-1:0] stretch_value(input logic [PW-1:0] pix);
        int unsigned quot;
        if (range_hi <= range_lo) begin
            return '0;
        end
        if (pix < range_lo) begin
            return '0;
        end
        if (pix > range_hi) begin
            return gcs_pkg::FULL_SCALE;
        end
        quot = ((int'(pix) - int'(range_lo)) * int'(gcs_pkg::FULL_SCALE))
               / (int'(range_hi) - int'(range_lo));
        if (quot > int'(gcs_pkg::FULL_SCALE)) begin
            quot = int'(gcs_pkg::FULL_SCALE);
        end
        return quot[PW-1:0];
    endfunction

    // Present one pixel, hold it until the transfer, then advance the predictor.
    task automatic send_pixel(input logic act, input logic fst, input logic [PW-1:0] pix,
                              input logic known, input logic [PW-1:0] known_val,
                              input bit gaps);
        bit took;
        if (gaps && !calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_first  <= fst;
        s_pixel  <= pix;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = (s_ready === 1'b1);
            @(posedge aclk);
        end
        if (act == ACT_STRETCH) begin
            stretched_q.push_back(known ? known_val : stretch_value(pix));
        end else if (fst) begin
            range_lo = pix;
            range_hi = pix;
        end else begin
            if (pix < range_lo) range_lo = pix;
            if (pix > range_hi) range_hi = pix;
        end
        n_items++;
    endtask

    task automatic wait_drained();
        while (stretched_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: ready runs and stall bursts, always ready in the closing stretch.
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (rx_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                rx_left <= $urandom_range(1, 16);
            end else begin
                m_ready <= 1'b1;
                rx_left <= $urandom_range(1, 40);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // Sample mid-cycle: a result seen here transfers at the next rising edge.
    always @(negedge aclk) begin : result_check
        logic [PW-1:0] want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (stretched_q.size() == 0) begin
                $error("stretched: expected none, actual %0d", m_stretched);
                err_count++;
            end else begin
                want = stretched_q.pop_front();
                if (m_stretched !== want) begin
                    $error("stretched: expected %0d, actual %0d", want, m_stretched);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int  lo_b;
        int  hi_b;
        int  n_meas;
        int  n_str;
        int  pix;
        bit  gaps;
        bit  restart;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = ACT_MEASURE;
        s_first     = 1'b0;
        s_pixel     = '0;
        m_ready     = 1'b0;
        calm        = 1'b0;
        rx_left     = 0;
        err_count   = 0;
        n_items     = 0;
        cycle_count = 0;
        range_lo    = gcs_pkg::MIN_RESET;
        range_hi    = gcs_pkg::MAX_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_pixel(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].first,
                       DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].known,
                       DIRECTED_ROWS[i].value, 1'b1);
        end
        // Hold the sender until the directed results have all come back.
        s_valid <= 1'b0;
        wait_drained();

        while (n_items < TOTAL_ITEMS) begin
            calm <= (n_items >= TOTAL_ITEMS - CALM_ITEMS);
            gaps = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any mix of passes and flags
                repeat ($urandom_range(1, 6)) begin
                    send_pixel(1'($urandom), 1'($urandom), PW'($urandom), 1'b0, '0, gaps);
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        lo_b = 0;
                        hi_b = 255;
                    end
                    1: begin
                        lo_b = $urandom_range(0, 255);
                        hi_b = lo_b + $urandom_range(0, 8);
                        if (hi_b > 255) hi_b = 255;
                    end
                    2: begin
                        lo_b = $urandom_range(0, 255);
                        hi_b = lo_b;
                    end
                    default: begin
                        lo_b = $urandom_range(0, 40);
                        hi_b = $urandom_range(215, 255);
                    end
                endcase
                // Now and then leave out the restart and carry the old range on.
                restart = ($urandom_range(0, 7) != 0);
                n_meas  = $urandom_range(1, 16);
                for (int k = 0; k < n_meas; k++) begin
                    send_pixel(ACT_MEASURE, (k == 0) && restart,
                               PW'($urandom_range(lo_b, hi_b)), 1'b0, '0, gaps);
                end
                n_str = $urandom_range(1, 24);
                for (int k = 0; k < n_str; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        pix = $urandom_range(0, 255);
                    end else begin
                        pix = $urandom_range((lo_b > 3) ? lo_b - 3 : 0,
                                             (hi_b < 252) ? hi_b + 3 : 255);
                    end
                    send_pixel(ACT_STRETCH, 1'($urandom), PW'(pix), 1'b0, '0, gaps);
                end
                if ($urandom_range(0, 19) == 0) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
            end
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gcs_pkg.sv
sv/gcs_front.sv
sv/gcs_queue.sv
sv/gcs_divide.sv
sv/grey_contrast_stretch_core.sv
bench/tb.sv
